// ===== hdl/gregorian_day_number_converter_top_assert.svh =====
// assertion macros for the day number converter
// each macro expects clk and rst_n in the scope where it is used
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_TOP_ASSERT_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define GDN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define GDN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GDN_ASSERT(label, prop, msg)
`define GDN_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/gdn_pkg.sv =====
`default_nettype none

package gdn_pkg;

  // calendar range
  localparam int unsigned MAX_YEAR = 9999;

  // field widths
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned SERIAL_W = 22;

  // cycle lengths in days
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;

  // largest day number that fits the result field
  localparam int unsigned SERIAL_MAX = (2 ** SERIAL_W) - 1;

  // day number of the last day of the last supported year
  localparam int unsigned LAST_SERIAL =
    DAYS_1Y * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  // reciprocals for constant division, each followed by a shift
  localparam int unsigned RECIP_25     = 5243;     // shift 17, exact for x < 40000
  localparam int unsigned RECIP_146097 = 29398;    // shift 32, low by at most one
  localparam int unsigned RECIP_1461   = 11483;    // shift 24, low by at most one

  // month codes used in compares
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // pipeline depth: input register, eight work stages, result register
  localparam int unsigned STAGES = 10;

  // days in all months before month m of a common year
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // length of month m in a common year, zero for a bad month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                      n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        n = 5'd31;
      default:                   n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gdn_in_if.sv =====
`default_nettype none

// input channel: one conversion request per beat
interface gdn_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [gdn_pkg::YEAR_W-1:0]    year_in;
  logic [gdn_pkg::MONTH_W-1:0]   month_in;
  logic [gdn_pkg::DAY_W-1:0]     day_in;
  logic [gdn_pkg::SERIAL_W-1:0]  serial_in;

  modport source (
    output valid, func, year_in, month_in, day_in, serial_in,
    input  ready
  );

  modport sink (
    input  valid, func, year_in, month_in, day_in, serial_in,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/gdn_out_if.sv =====
`default_nettype none

// result channel: one conversion result per beat
interface gdn_out_if;
  logic                          valid;
  logic                          ready;
  logic                          valid_res;
  logic [gdn_pkg::SERIAL_W-1:0]  serial_out;
  logic [gdn_pkg::YEAR_W-1:0]    year_out;
  logic [gdn_pkg::MONTH_W-1:0]   month_out;
  logic [gdn_pkg::DAY_W-1:0]     day_out;

  modport source (
    output valid, valid_res, serial_out, year_out, month_out, day_out,
    input  ready
  );

  modport sink (
    input  valid, valid_res, serial_out, year_out, month_out, day_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/gregorian_day_number_converter_top.sv =====
// channel   dir   handshake      beat contents
// in_ch     in    valid/ready    func, year_in, month_in, day_in, serial_in
// out_ch    out   valid/ready    valid_res, serial_out, year_out, month_out, day_out
//
// one beat in and one beat out per cycle when neither side stalls
// the pipeline is an input register, eight work stages and a result register
// the depth is set by the day number split, two reciprocal multiplies each
// followed by a one-step correction, then the year and month selection
// each stage holds its beat while the next one is full and holding, bubbles close up
// rst_n clears only the stage valid bits

`default_nettype none

`include "gregorian_day_number_converter_top_assert.svh"

module gregorian_day_number_converter_top (
  input wire logic  clk,
  input wire logic  rst_n,
  gdn_in_if.sink    in_ch,
  gdn_out_if.source out_ch
);

  localparam int unsigned LAST = gdn_pkg::STAGES - 1;

  // work record carried down the pipeline
  typedef struct packed {
    logic        func;
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] serial;
    logic [13:0] p;
    logic [24:0] prod_c;
    logic [22:0] prod_q;
    logic        leap;
    logic [22:0] n;
    logic [21:0] r;
    logic [36:0] prod;
    logic [4:0]  q400;
    logic [1:0]  q100;
    logic [4:0]  q4;
    logic [1:0]  q1;
    logic [13:0] y;
    logic [21:0] serial_res;
    logic [13:0] year_res;
    logic [3:0]  month_res;
    logic [4:0]  day_res;
  } work_t;

  work_t                     st_r   [gdn_pkg::STAGES];
  work_t                     st_nxt [gdn_pkg::STAGES];
  logic [gdn_pkg::STAGES-1:0] v_r;
  logic [gdn_pkg::STAGES-1:0] adv;

  // stage load enables, a stage moves when empty or when its successor moves
  always_comb begin
    adv[LAST] = !v_r[LAST] || out_ch.ready;
    for (int k = int'(LAST) - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  // capture the input beat
  always_comb begin : st0_comb
    work_t w;
    w        = '0;
    w.func   = in_ch.func;
    w.year   = in_ch.year_in;
    w.month  = in_ch.month_in;
    w.day    = in_ch.day_in;
    w.serial = in_ch.serial_in;
    st_nxt[0] = w;
  end

  // range checks, quotient estimates by reciprocal multiply
  always_comb begin : st1_comb
    work_t w;
    w        = st_r[0];
    w.p      = w.year - 14'd1;
    w.prod_c = 25'(w.p[13:2]) * 25'(gdn_pkg::RECIP_25);
    w.prod_q = 23'(w.p[13:4]) * 23'(gdn_pkg::RECIP_25);
    w.r      = w.serial - 22'd1;
    w.prod   = 37'(w.r) * 37'(gdn_pkg::RECIP_146097);
    if (!w.func) begin
      w.ok = (w.year != 14'd0) && (32'(w.year) <= gdn_pkg::MAX_YEAR) &&
             (w.month >= gdn_pkg::MONTH_JAN) && (w.month <= gdn_pkg::MONTH_DEC);
    end else begin
      w.ok = (w.serial != 22'd0) && (32'(w.serial) <= gdn_pkg::LAST_SERIAL);
    end
    st_nxt[1] = w;
  end

  // days before the year and leap test; 400 year remainder estimate
  always_comb begin : st2_comb
    work_t       w;
    logic [7:0]  c100;
    logic [5:0]  c400;
    logic [14:0] pm100;
    logic [14:0] pm400;
    logic [4:0]  q;
    w     = st_r[1];
    c100  = w.prod_c[24:17];
    c400  = w.prod_q[22:17];
    pm100 = 15'(w.p) - 15'(c100) * 15'd100;
    pm400 = 15'(w.p) - 15'(c400) * 15'd400;
    w.n   = 23'(w.p) * 23'(gdn_pkg::DAYS_1Y) + 23'(w.p[13:2]) - 23'(c100) + 23'(c400);
    if (!w.func) begin
      w.leap = (w.year[1:0] == 2'd0) && ((pm100 != 15'd99) || (pm400 == 15'd399));
    end
    q      = w.prod[36:32];
    w.q400 = q;
    w.r    = w.r - 22'(q) * 22'(gdn_pkg::DAYS_400Y);
    st_nxt[2] = w;
  end

  // day check and day number sum; 400 year correction
  always_comb begin : st3_comb
    work_t       w;
    logic [4:0]  mlen;
    logic [22:0] nn;
    w = st_r[2];
    if (!w.func) begin
      mlen = gdn_pkg::month_len(w.month) +
             5'((w.month == gdn_pkg::MONTH_FEB) && w.leap);
      nn   = w.n + 23'(gdn_pkg::days_before_month(w.month)) + 23'(w.day) +
             23'((w.month > gdn_pkg::MONTH_FEB) && w.leap);
      w.ok = w.ok && (w.day != 5'd0) && (w.day <= mlen) &&
             (32'(nn) <= gdn_pkg::SERIAL_MAX);
      w.n  = nn;
    end else begin
      mlen = '0;
      nn   = '0;
      if (w.r >= 22'(gdn_pkg::DAYS_400Y)) begin
        w.r    = w.r - 22'(gdn_pkg::DAYS_400Y);
        w.q400 = w.q400 + 5'd1;
      end
    end
    st_nxt[3] = w;
  end

  // century within the 400 year cycle, last day stays in the fourth century
  always_comb begin : st4_comb
    work_t w;
    w = st_r[3];
    priority if (w.r >= 22'(3 * gdn_pkg::DAYS_100Y)) begin
      w.q100 = 2'd3;
    end else if (w.r >= 22'(2 * gdn_pkg::DAYS_100Y)) begin
      w.q100 = 2'd2;
    end else if (w.r >= 22'(gdn_pkg::DAYS_100Y)) begin
      w.q100 = 2'd1;
    end else begin
      w.q100 = 2'd0;
    end
    w.r = w.r - 22'(w.q100) * 22'(gdn_pkg::DAYS_100Y);
    st_nxt[4] = w;
  end

  // 4 year cycle estimate by reciprocal multiply
  always_comb begin : st5_comb
    work_t w;
    w      = st_r[4];
    w.prod = 37'(w.r[15:0]) * 37'(gdn_pkg::RECIP_1461);
    st_nxt[5] = w;
  end

  // 4 year remainder from the estimate
  always_comb begin : st6_comb
    work_t w;
    w    = st_r[5];
    w.q4 = w.prod[28:24];
    w.r  = w.r - 22'(w.q4) * 22'(gdn_pkg::DAYS_4Y);
    st_nxt[6] = w;
  end

  // 4 year correction
  always_comb begin : st7_comb
    work_t w;
    w = st_r[6];
    if (w.r >= 22'(gdn_pkg::DAYS_4Y)) begin
      w.r  = w.r - 22'(gdn_pkg::DAYS_4Y);
      w.q4 = w.q4 + 5'd1;
    end
    st_nxt[7] = w;
  end

  // year within the 4 year cycle, year number and leap flag
  always_comb begin : st8_comb
    work_t w;
    w = st_r[7];
    priority if (w.r >= 22'(3 * gdn_pkg::DAYS_1Y)) begin
      w.q1 = 2'd3;
    end else if (w.r >= 22'(2 * gdn_pkg::DAYS_1Y)) begin
      w.q1 = 2'd2;
    end else if (w.r >= 22'(gdn_pkg::DAYS_1Y)) begin
      w.q1 = 2'd1;
    end else begin
      w.q1 = 2'd0;
    end
    w.r = w.r - 22'(w.q1) * 22'(gdn_pkg::DAYS_1Y);
    w.y = 14'(w.q400) * 14'd400 + 14'(w.q100) * 14'd100 + 14'(w.q4) * 14'd4 +
          14'(w.q1) + 14'd1;
    if (w.func) begin
      // century years leap only at the end of the 400 year cycle
      w.leap = (w.q1 == 2'd3) && ((w.q4 != 5'd24) || (w.q100 == 2'd3));
    end
    st_nxt[8] = w;
  end

  // month walk over the day of the year, result fields
  always_comb begin : st9_comb
    work_t      w;
    logic [8:0] s;
    logic [8:0] start;
    logic [3:0] mo;
    logic [4:0] d;
    w     = st_r[8];
    mo    = gdn_pkg::MONTH_JAN;
    start = 9'd0;
    for (int k = 2; k <= 12; k++) begin
      s = gdn_pkg::days_before_month(4'(k)) + 9'((k > 2) && w.leap);
      if (w.r[8:0] >= s) begin
        mo    = 4'(k);
        start = s;
      end
    end
    d = 5'(w.r[8:0] - start + 9'd1);
    w.serial_res = (w.ok && !w.func) ? w.n[21:0] : '0;
    w.year_res   = (w.ok && w.func) ? w.y : '0;
    w.month_res  = (w.ok && w.func) ? mo : '0;
    w.day_res    = (w.ok && w.func) ? d : '0;
    st_nxt[9] = w;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k <= int'(LAST); k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int k = 0; k <= int'(LAST); k++) begin
      if (adv[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // result beat
  assign out_ch.valid      = v_r[LAST];
  assign out_ch.valid_res  = st_r[LAST].ok;
  assign out_ch.serial_out = st_r[LAST].serial_res;
  assign out_ch.year_out   = st_r[LAST].year_res;
  assign out_ch.month_out  = st_r[LAST].month_res;
  assign out_ch.day_out    = st_r[LAST].day_res;

  // an invalid result carries all-zero fields
  `GDN_ASSERT(a_invalid_zero, !(out_ch.valid && !out_ch.valid_res) || ((out_ch.serial_out == 22'd0) && (out_ch.year_out == 14'd0) && (out_ch.month_out == 4'd0) && (out_ch.day_out == 5'd0)), "invalid result with nonzero fields")

  // a valid date result has a real month and day
  `GDN_ASSERT(a_date_form, !(out_ch.valid && out_ch.valid_res && (out_ch.year_out != 14'd0)) || ((out_ch.month_out >= gdn_pkg::MONTH_JAN) && (out_ch.month_out <= gdn_pkg::MONTH_DEC) && (out_ch.day_out != 5'd0)), "date result out of form")

  // a valid day number result stays within the calendar range
  `GDN_ASSERT(a_serial_range, !(out_ch.valid && out_ch.valid_res) || (32'(out_ch.serial_out) <= gdn_pkg::LAST_SERIAL), "day number past the last supported day")

  // an accepted beat always lands in the input register
  `GDN_ASSERT_NEXT(a_capture, in_ch.valid && in_ch.ready, v_r[0], "accepted beat lost at input")

endmodule

`default_nettype wire

// ===== tb/gdn_tb_pkg.sv =====
package gdn_tb_pkg;

  // conversion direction carried on the func bit
  typedef enum logic {
    FN_DATE_TO_SERIAL = 1'b0,
    FN_SERIAL_TO_DATE = 1'b1
  } conv_func_t;

endpackage

// ===== tb/gdn_checker.sv =====
module gdn_checker
  import gdn_pkg::*;
  import gdn_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  gdn_in_if           in_mon,
  gdn_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                valid_res;
    logic [SERIAL_W-1:0] serial;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } conv_result_t;

  conv_result_t expected_results[$];
  int unsigned  mismatches = 0;
  int unsigned  outstanding = 0;

  assign fail_count    = mismatches;
  assign pending_count = outstanding;

  function automatic bit is_leap_year(int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    int unsigned n;
    case (m)
      2:           n = is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  // days in all whole years before year y
  function automatic int unsigned days_before_year(int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * DAYS_1Y + p / 4 - p / 100 + p / 400;
  endfunction

  // expected result beat for one request beat
  function automatic conv_result_t predict_conversion(logic func, logic [YEAR_W-1:0] year_f,
                                                      logic [MONTH_W-1:0] month_f,
                                                      logic [DAY_W-1:0] day_f,
                                                      logic [SERIAL_W-1:0] serial_f);
    conv_result_t res;
    int unsigned  y;
    int unsigned  m;
    int unsigned  d;
    int unsigned  total;
    int unsigned  r;
    int unsigned  q400;
    int unsigned  q100;
    int unsigned  q4;
    int unsigned  q1;
    res = '0;
    y = year_f;
    m = month_f;
    d = day_f;
    if (func == FN_DATE_TO_SERIAL) begin
      if (y >= 1 && y <= MAX_YEAR && m >= MONTH_JAN && m <= MONTH_DEC &&
          d >= 1 && d <= days_in_month(y, m)) begin
        total = days_before_year(y) + d;
        for (int k = 1; k < m; k++) total += days_in_month(y, k);
        if (total <= SERIAL_MAX) begin
          res.valid_res = 1'b1;
          res.serial    = SERIAL_W'(total);
        end
      end
    end else if (serial_f >= 1 && serial_f <= LAST_SERIAL) begin
      r    = serial_f - 1;
      q400 = r / DAYS_400Y;
      r    = r - q400 * DAYS_400Y;
      // last day of a 400 year cycle stays in the fourth century
      q100 = r / DAYS_100Y;
      if (q100 > 3) q100 = 3;
      r    = r - q100 * DAYS_100Y;
      q4   = r / DAYS_4Y;
      r    = r - q4 * DAYS_4Y;
      // last day of a 4 year cycle stays in the leap year
      q1   = r / DAYS_1Y;
      if (q1 > 3) q1 = 3;
      r    = r - q1 * DAYS_1Y;
      y    = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
      m    = 1;
      while (m < 12 && r >= days_in_month(y, m)) begin
        r = r - days_in_month(y, m);
        m++;
      end
      res.valid_res = 1'b1;
      res.year      = YEAR_W'(y);
      res.month     = MONTH_W'(m);
      res.day       = DAY_W'(r + 1);
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // result beats retire before request beats of the same edge are queued
  always @(posedge clk) begin
    conv_result_t want;
    conv_result_t got;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        got.valid_res = out_mon.valid_res;
        got.serial    = out_mon.serial_out;
        got.year      = out_mon.year_out;
        got.month     = out_mon.month_out;
        got.day       = out_mon.day_out;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, got valid_res %0d serial %0d %0d-%0d-%0d",
                   $time, got.valid_res, got.serial, got.year, got.month, got.day);
        end else begin
          want = expected_results.pop_front();
          check_field("valid_res", want.valid_res, got.valid_res);
          check_field("serial_out", want.serial, got.serial);
          check_field("year_out", want.year, got.year);
          check_field("month_out", want.month, got.month);
          check_field("day_out", want.day, got.day);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_conversion(in_mon.func, in_mon.year_in,
                                                      in_mon.month_in, in_mon.day_in,
                                                      in_mon.serial_in));
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gdn_pkg::*;
  import gdn_tb_pkg::*;

  typedef struct {
    conv_func_t          func;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [SERIAL_W-1:0] serial;
  } conv_request_t;

  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES    = STAGES + 6;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 57;
  bit          long_hold = 1'b0;
  int unsigned fail_count;
  int unsigned pending_count;

  gdn_in_if  in_ch ();
  gdn_out_if out_ch ();

  gregorian_day_number_converter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gdn_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one request beat, possibly after idle cycles, and hold it until taken
  task automatic send_request(input conv_request_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= req.func;
    in_ch.year_in   <= req.year;
    in_ch.month_in  <= req.month;
    in_ch.day_in    <= req.day;
    in_ch.serial_in <= req.serial;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // date request with junk in the unused day number field
  task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
    conv_request_t req;
    req.func   = FN_DATE_TO_SERIAL;
    req.year   = YEAR_W'(y);
    req.month  = MONTH_W'(m);
    req.day    = DAY_W'(d);
    req.serial = SERIAL_W'($urandom);
    send_request(req);
  endtask

  // day number request with junk in the unused date fields
  task automatic send_serial(input int unsigned s);
    conv_request_t req;
    req.func   = FN_SERIAL_TO_DATE;
    req.year   = YEAR_W'($urandom);
    req.month  = MONTH_W'($urandom);
    req.day    = DAY_W'($urandom);
    req.serial = SERIAL_W'(s);
    send_request(req);
  endtask

  // mostly legal dates and day numbers, biased toward leap and cycle boundaries
  function automatic conv_request_t random_request();
    conv_request_t req;
    int unsigned   pick;
    int unsigned   period;
    req.func   = conv_func_t'($urandom_range(0, 1));
    req.year   = YEAR_W'($urandom_range(1, MAX_YEAR));
    req.month  = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
    req.day    = DAY_W'($urandom_range(1, 28));
    req.serial = SERIAL_W'($urandom_range(1, LAST_SERIAL));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // month ends
      req.day = DAY_W'($urandom_range(29, 31));
    end else if (pick < 30) begin
      // february of leap candidates, centuries included
      req.year  = YEAR_W'($urandom_range(0, 1) ? 100 * $urandom_range(1, 99)
                                               : 4 * $urandom_range(1, 2499));
      req.month = MONTH_FEB;
      req.day   = DAY_W'($urandom_range(28, 29));
    end else if (pick < 40) begin
      // day numbers around the end of a year or a long cycle
      case ($urandom_range(0, 3))
        0:       period = DAYS_400Y;
        1:       period = DAYS_100Y;
        2:       period = DAYS_4Y;
        default: period = DAYS_1Y;
      endcase
      req.serial = SERIAL_W'(period * $urandom_range(1, LAST_SERIAL / period)
                             + $urandom_range(0, 2) - 1);
    end else if (pick < 48) begin
      // anything the fields can hold
      req.year   = YEAR_W'($urandom_range(0, 2 ** YEAR_W - 1));
      req.month  = MONTH_W'($urandom_range(0, 2 ** MONTH_W - 1));
      req.day    = DAY_W'($urandom_range(0, 2 ** DAY_W - 1));
      req.serial = SERIAL_W'($urandom_range(0, 2 ** SERIAL_W - 1));
    end
    return req;
  endfunction

  // drop valid and wait for every outstanding result beat
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // request side and verdict
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.func      = FN_DATE_TO_SERIAL;
    in_ch.year_in   = '0;
    in_ch.month_in  = '0;
    in_ch.day_in    = '0;
    in_ch.serial_in = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // calendar extremes, leap rules and bad dates
    send_date(1, MONTH_JAN, 1);
    send_date(MAX_YEAR, MONTH_DEC, 31);
    send_date(2000, MONTH_FEB, 29);
    send_date(1900, MONTH_FEB, 29);
    send_date(2004, MONTH_FEB, 29);
    send_date(2001, MONTH_FEB, 29);
    send_date(2000, 3, 1);
    send_date(0, MONTH_JAN, 1);
    send_date(MAX_YEAR + 1, MONTH_JAN, 1);
    send_date(2 ** YEAR_W - 1, 2 ** MONTH_W - 1, 2 ** DAY_W - 1);
    send_date(2024, 0, 10);
    send_date(2024, 13, 10);
    send_date(2024, 4, 31);
    send_date(2024, 6, 0);
    // day number extremes and the last day of each cycle
    send_serial(0);
    send_serial(1);
    send_serial(DAYS_1Y);
    send_serial(DAYS_4Y);
    send_serial(DAYS_100Y);
    send_serial(DAYS_400Y - 1);
    send_serial(DAYS_400Y);
    send_serial(LAST_SERIAL);
    send_serial(LAST_SERIAL + 1);
    send_serial(2 ** SERIAL_W - 1);

    // sender idles lightly, receiver stalls heavily
    repeat (300) send_request(random_request());

    // and the other way round
    send_idle_pct = 57;
    recv_idle_pct <= 19;
    repeat (250) send_request(random_request());

    // sender pause until the pipe is empty
    drain_results();

    // full rate with one long receiver hold-off to back the pipe up
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    long_hold     <= 1'b1;
    repeat (300) send_request(random_request());

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #1ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
